@@ src/bdpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpe_pkg
// Shared types and constants of the button debounce and press event unit.
// ----------------------------------------------------------------------------
package bdpe_pkg;

  localparam int NumButtonsDefault = 8;

  localparam int IdxW      = 3;
  localparam int IntegW    = 8;
  localparam int HoldW     = 16;
  localparam int OwnerW    = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int InDataW   = 8;
  localparam int OutDataW  = 8;

  localparam logic             ActiveHighRst       = 1'b1;
  localparam logic             DebounceEnableRst   = 1'b1;
  localparam logic [IntegW-1:0] IntegratorMaxRst   = 8'd5;
  localparam logic [HoldW-1:0]  LongPressTicksRst  = 16'd100;
  localparam logic             ShortEnableRst      = 1'b1;
  localparam logic             ReleaseEnableRst    = 1'b1;
  localparam logic             LongEnableRst       = 1'b1;
  localparam logic             ReleaseAfterLongRst = 1'b0;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_SHORT   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } event_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_TICK   = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_HIGH        = 3'd0,
    CFG_DEBOUNCE_ENABLE    = 3'd1,
    CFG_INTEGRATOR_MAX     = 3'd2,
    CFG_LONG_PRESS_TICKS   = 3'd3,
    CFG_SHORT_ENABLE       = 3'd4,
    CFG_RELEASE_ENABLE     = 3'd5,
    CFG_LONG_ENABLE        = 3'd6,
    CFG_RELEASE_AFTER_LONG = 3'd7
  } cfg_reg_e;

  // per button state word: integrator and debounced level
  typedef struct packed {
    logic [IntegW-1:0] integ;
    logic              level;
  } entry_t;

endpackage

@@ src/button_debounce_press_events_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_events_unit
// Debounces push buttons and reports short press, release and long press.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per cycle while the receiver is ready: tuser
//   is the action (sample or tick), tdata holds the button index and the raw
//   pin level. Every request gives exactly one result on m_axis: event code,
//   button and debounced level. The cfg channel writes one register per
//   cycle and is always ready; write it only while no request is in flight.
//   Per button state (integrator and level) sits in a small synchronous
//   memory read at accept time and written back when the request moves on to
//   the output register; a write to the entry being read in the same cycle
//   is forwarded. Owner, hold counter and long press flag live in registers.
//   Throughput is one request per cycle while the receiver is ready, set by
//   the single read/modify/write pass through the state memory. Reset clears
//   the global state and the valid bits of the memory and loads register
//   defaults. When the receiver stalls, the output register holds and the
//   compute stage holds behind it, so at most two requests are buffered.
// ----------------------------------------------------------------------------
module button_debounce_press_events_unit #(
  parameter int NUM_BUTTONS = bdpe_pkg::NumButtonsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] button_index, [3] raw_level, [7:4] zero
  input  logic [bdpe_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] action
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] event_res, [4:2] event_button, [5] debounced_level, [7:6] zero
  output logic [bdpe_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bdpe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bdpe_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int AddrW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [bdpe_pkg::OwnerW-1:0] NumBtn = bdpe_pkg::OwnerW'(NUM_BUTTONS);
  localparam logic [bdpe_pkg::HoldW-1:0]  HoldMax = '1;

  // configuration registers
  logic                          active_high_q;
  logic                          debounce_enable_q;
  logic [bdpe_pkg::IntegW-1:0]   integrator_max_q;
  logic [bdpe_pkg::HoldW-1:0]    long_press_ticks_q;
  logic                          short_enable_q;
  logic                          release_enable_q;
  logic                          long_enable_q;
  logic                          release_after_long_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_high_q        <= bdpe_pkg::ActiveHighRst;
      debounce_enable_q    <= bdpe_pkg::DebounceEnableRst;
      integrator_max_q     <= bdpe_pkg::IntegratorMaxRst;
      long_press_ticks_q   <= bdpe_pkg::LongPressTicksRst;
      short_enable_q       <= bdpe_pkg::ShortEnableRst;
      release_enable_q     <= bdpe_pkg::ReleaseEnableRst;
      long_enable_q        <= bdpe_pkg::LongEnableRst;
      release_after_long_q <= bdpe_pkg::ReleaseAfterLongRst;
    end else if (cfg_valid_i) begin
      unique case (bdpe_pkg::cfg_reg_e'(cfg_index_i))
        bdpe_pkg::CFG_ACTIVE_HIGH:        active_high_q        <= cfg_data_i[0];
        bdpe_pkg::CFG_DEBOUNCE_ENABLE:    debounce_enable_q    <= cfg_data_i[0];
        bdpe_pkg::CFG_INTEGRATOR_MAX:
          integrator_max_q <= cfg_data_i[bdpe_pkg::IntegW-1:0];
        bdpe_pkg::CFG_LONG_PRESS_TICKS:   long_press_ticks_q   <= cfg_data_i;
        bdpe_pkg::CFG_SHORT_ENABLE:       short_enable_q       <= cfg_data_i[0];
        bdpe_pkg::CFG_RELEASE_ENABLE:     release_enable_q     <= cfg_data_i[0];
        bdpe_pkg::CFG_LONG_ENABLE:        long_enable_q        <= cfg_data_i[0];
        bdpe_pkg::CFG_RELEASE_AFTER_LONG: release_after_long_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline control
  logic s1_vld_q, out_vld_q;
  logic out_load, s1_go, in_acc;

  assign out_load      = !out_vld_q || m_axis_tready;
  assign s1_go         = s1_vld_q && out_load;
  assign s_axis_tready = !s1_vld_q || out_load;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;

  logic [bdpe_pkg::IdxW-1:0] in_idx;
  logic [AddrW-1:0]          in_addr;
  assign in_idx  = s_axis_tdata[bdpe_pkg::IdxW-1:0];
  assign in_addr = AddrW'(in_idx);

  // stage 1 request registers
  logic                      s1_tick_q;
  logic [bdpe_pkg::IdxW-1:0] s1_idx_q;
  logic                      s1_raw_q;
  logic [AddrW-1:0]          s1_addr;
  assign s1_addr = AddrW'(s1_idx_q);

  // state memory, valid bits and forwarding
  bdpe_pkg::entry_t mem_q [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] vld_q;
  bdpe_pkg::entry_t rd_q, fwd_data_q, cur, nxt;
  logic rd_vld_q, fwd_q;
  logic wr_en;

  // global state
  logic [bdpe_pkg::OwnerW-1:0] owner_q, owner_d;
  logic [bdpe_pkg::HoldW-1:0]  hold_q, hold_d;
  logic                        long_fired_q, long_fired_d;

  logic in_range;
  logic [bdpe_pkg::OwnerW-1:0] self_id;
  logic [bdpe_pkg::IntegW-1:0] v;
  logic now_p, last_p, is_owner;
  bdpe_pkg::event_e ev;
  logic [bdpe_pkg::IdxW-1:0] res_btn;
  logic res_lvl;

  assign in_range = ({1'b0, s1_idx_q} < NumBtn);
  assign self_id  = {1'b0, s1_idx_q} + 4'd1;
  assign cur      = fwd_q ? fwd_data_q : (rd_vld_q ? rd_q : '0);
  assign wr_en    = s1_go && !s1_tick_q && in_range;

  always_comb begin
    v            = cur.integ;
    nxt          = cur;
    owner_d      = owner_q;
    hold_d       = hold_q;
    long_fired_d = long_fired_q;
    ev           = bdpe_pkg::EV_NONE;
    res_btn      = '0;
    res_lvl      = 1'b0;
    now_p        = 1'b0;
    last_p       = 1'b0;
    is_owner     = 1'b0;
    if (s1_tick_q) begin
      if (long_enable_q && owner_q != '0 && !long_fired_q && hold_q != HoldMax) begin
        hold_d = hold_q + 16'd1;
      end
    end else begin
      res_btn = s1_idx_q;
      if (in_range) begin
        if (debounce_enable_q) begin
          if (!s1_raw_q) begin
            if (v != '0) v = v - 8'd1;
          end else if (v < integrator_max_q) begin
            v = v + 8'd1;
          end
          if (v == '0) begin
            nxt.level = 1'b0;
          end else if (v >= integrator_max_q) begin
            v = integrator_max_q;
            nxt.level = 1'b1;
          end
          nxt.integ = v;
        end else begin
          nxt.level = s1_raw_q;
        end
        now_p    = (nxt.level == active_high_q);
        last_p   = (cur.level == active_high_q);
        is_owner = (owner_q == self_id);
        if (now_p && !last_p && owner_q == '0) begin
          owner_d = self_id;
          if (short_enable_q) ev = bdpe_pkg::EV_SHORT;
        end else if (last_p && !now_p && is_owner) begin
          if (release_enable_q &&
              !(long_enable_q && !release_after_long_q && long_fired_q)) begin
            ev = bdpe_pkg::EV_RELEASE;
          end
          long_fired_d = 1'b0;
          hold_d       = '0;
          owner_d      = '0;
        end else if (long_enable_q && is_owner && !long_fired_q &&
                     hold_q >= long_press_ticks_q) begin
          hold_d       = '0;
          long_fired_d = 1'b1;
          ev           = bdpe_pkg::EV_LONG;
        end
        res_lvl = nxt.level;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_addr] <= nxt;
    end
    if (in_acc) begin
      rd_q       <= mem_q[in_addr];
      fwd_data_q <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_en) vld_q[s1_addr] <= 1'b1;
      if (in_acc) begin
        rd_vld_q <= vld_q[in_addr];
        fwd_q    <= wr_en && (s1_addr == in_addr);
      end
    end
  end

  // request stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_tick_q <= (bdpe_pkg::action_e'(s_axis_tuser) == bdpe_pkg::ACT_TICK);
      s1_idx_q  <= in_idx;
      s1_raw_q  <= s_axis_tdata[bdpe_pkg::IdxW];
    end
  end

  // global state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q      <= '0;
      hold_q       <= '0;
      long_fired_q <= 1'b0;
    end else if (s1_go) begin
      owner_q      <= owner_d;
      hold_q       <= hold_d;
      long_fired_q <= long_fired_d;
    end
  end

  // output register
  logic [1:0]                out_ev_q;
  logic [bdpe_pkg::IdxW-1:0] out_btn_q;
  logic                      out_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_ev_q  <= ev;
      out_btn_q <= res_btn;
      out_lvl_q <= res_lvl;
    end
  end

  assign m_axis_tdata = {2'b00, out_lvl_q, out_btn_q, out_ev_q};

  // checks
  a_owner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owner_q <= NumBtn)
    else $error("owner out of range");

  a_long_needs_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_fired_q |-> owner_q != '0)
    else $error("long press flag without owner");

  a_hold_needs_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q != '0 |-> owner_q != '0)
    else $error("hold counter running without owner");

endmodule
